// ===== hdl/rqr_pkg.sv =====
// Shared types, codes and defaults for the ready queue with rotate and remove.
package rqr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TAG_WIDTH     = 16;

   typedef enum logic [1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_DEQUEUE = 2'd1,
      MODE_ROTATE  = 2'd2,
      MODE_REMOVE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH,
      OP_POP,
      OP_ROTATE,
      OP_DELETE
   } op_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [TAG_WIDTH-1:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TAG_WIDTH-1:0] tag_out;
      logic [4:0]           count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       scan_step;
      op_type     op;
      logic       rsp_load;
      status_type rsp_status;
      logic       take_head;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     empty;
      logic     full;
      logic     hit;
      logic     last;
   } stat_type;

endpackage

// ===== hdl/rqr_datapath.sv =====
// Datapath of the run queue: entry cells, occupancy, match scan and result register.
module rqr_datapath #(
   parameter int DEPTH = rqr_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  rqr_pkg::req_type req_data,
   input  rqr_pkg::cmd_type cmd,
   output rqr_pkg::stat_type stat,
   output rqr_pkg::rsp_type rsp_data
);
   import rqr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic [TAG_WIDTH-1:0] entries_ff [DEPTH];
   logic [TAG_WIDTH-1:0] entries_in [DEPTH];
   logic [TAG_WIDTH-1:0] upper      [DEPTH];
   logic [CW-1:0]        occ_ff;
   logic [CW-1:0]        occ_in;
   logic [DEPTH-1:0]     match_ff;
   logic [DEPTH-1:0]     match_in;
   logic [IW-1:0]        idx_ff;
   logic [IW-1:0]        idx_in;
   req_type              req_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic [CW-1:0]        del_pos;
   logic [CW+4:0]        count_ext;

   for (genvar g = 0; g < DEPTH; g++) begin : g_upper
      if (g < DEPTH - 1) begin : g_mid
         assign upper[g] = entries_ff[g+1];
      end else begin : g_end
         assign upper[g] = '0;
      end
   end

   always_comb begin
      del_pos = (cmd.op == OP_POP) ? '0 : CW'(idx_ff);
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         match_in[i]   = (entries_ff[i] == req_data.tag) && (CW'(i) < occ_ff);
         case (cmd.op)
            OP_PUSH: begin
               if (CW'(i) == occ_ff) begin
                  entries_in[i] = req_ff.tag;
               end
            end
            OP_POP, OP_DELETE: begin
               if (CW'(i) >= del_pos) begin
                  entries_in[i] = (CW'(i + 1) < occ_ff) ? upper[i] : '0;
               end
            end
            OP_ROTATE: begin
               if (CW'(i + 1) < occ_ff) begin
                  entries_in[i] = upper[i];
               end else if (CW'(i + 1) == occ_ff) begin
                  entries_in[i] = entries_ff[0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cmd.op)
         OP_PUSH:           occ_in = occ_ff + CW'(1);
         OP_POP, OP_DELETE: occ_in = occ_ff - CW'(1);
         default:           occ_in = occ_ff;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   assign count_ext = {5'b0, occ_in};

   always_comb begin
      rsp_in         = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status  = cmd.rsp_status;
         rsp_in.tag_out = cmd.take_head ? entries_ff[0] : '0;
         rsp_in.count   = count_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= '0;
         end
         occ_ff <= '0;
      end else begin
         entries_ff <= entries_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         match_ff <= match_in;
      end else if (cmd.scan_step) begin
         match_ff <= match_ff >> 1;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign stat.mode  = mode_type'(req_ff.mode);
   assign stat.empty = (occ_ff == '0);
   assign stat.full  = (occ_ff == CW'(DEPTH));
   assign stat.hit   = match_ff[0];
   assign stat.last  = ((CW'(idx_ff) + CW'(1)) >= occ_ff);
   assign rsp_data   = rsp_ff;

endmodule

// ===== hdl/rqr_controller.sv =====
// Controller of the run queue: sequences one transfer through execute, scan and response.
module rqr_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  rqr_pkg::stat_type stat,
   output rqr_pkg::cmd_type  cmd
);
   import rqr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.op     = OP_NOP;
      cmd.rsp_status = STATUS_OK;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            cmd.rsp_load = 1'b1;
            case (stat.mode)
               MODE_ENQUEUE: begin
                  if (stat.full) begin
                     cmd.rsp_status = STATUS_FULL;
                  end else begin
                     cmd.op = OP_PUSH;
                  end
               end
               MODE_DEQUEUE, MODE_ROTATE: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STATUS_EMPTY;
                  end else begin
                     cmd.op        = (stat.mode == MODE_DEQUEUE) ? OP_POP : OP_ROTATE;
                     cmd.take_head = 1'b1;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STATUS_EMPTY;
                  end else begin
                     cmd.rsp_load = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.op       = OP_DELETE;
               cmd.rsp_load = 1'b1;
               state_in     = ST_RESP;
            end else if (stat.last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_NOTFOUND;
               state_in       = ST_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ready_queue_with_rotate_remove_unit.sv =====
// Top level of the ready queue with rotate and remove.
// The queue holds up to DEPTH task tags in a row of cells with the head in the first cell, and
// starts empty after reset. One transfer is handled at a time: enqueue, dequeue and rotate give
// their result through the execute state and then the response register, and the next request
// is taken in the cycle after the result transfer. Remove first compares every cell against
// the tag in parallel, then steps through the match bits one cell per cycle from the head,
// stopping at the first match or the last occupied cell, so its result waits on that scan.
// Closing a gap, rotating and appending are each done on the whole cell row at once.
module ready_queue_with_rotate_remove_unit #(
   parameter int DEPTH = rqr_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rqr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rqr_pkg::rsp_type rsp_data
);
   import rqr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rqr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rqr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
